@@ rtl/ffsra_pkg.sv @@
// types, codes and fixed widths shared by the sector run allocator
// depends on nothing; every other file refers to it by scoped names
package ffsra_pkg;

   // fixed field widths
   localparam int SIZE_W    = 24;
   localparam int INDEX_W   = 12;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 13;
   localparam int ADDRESS_W = 20;

   // reset value of the sector count register
   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

   // request operations
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_SET   = 1'b1;

   // per-sector status codes
   localparam logic [STATUS_W-1:0] STAT_FREE  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_USED  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_END   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_START = 2'd3;

   typedef struct packed {
      logic                op;
      logic [SIZE_W-1:0]   alloc_size;
      logic [INDEX_W-1:0]  sector_index;
      logic [STATUS_W-1:0] status_code;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [INDEX_W-1:0]   start_sector;
      logic [ADDRESS_W-1:0] start_address;
      logic [COUNT_W-1:0]   sectors_taken;
   } rsp_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] need_count;
   } div_status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_MARK,
      S_DONE
   } state_type;

endpackage

@@ rtl/ffsra_ceil_div.sv @@
// constant divider for the sector count: reciprocal multiply over two registered
// steps, rounding up with a minimum of one; uses ffsra_pkg
module ffsra_ceil_div #(
   parameter int DIVISOR = 255
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ffsra_pkg::SIZE_W-1:0]      dividend,
   output ffsra_pkg::div_status_type         status
);

   localparam int SW    = ffsra_pkg::SIZE_W;
   localparam int XW    = SW + 1;                  // dividend plus divisor - 1
   localparam int LW    = $clog2(DIVISOR);
   localparam int SHIFT = XW + LW;
   localparam int PW    = SHIFT + SW;
   // ceil(2^SHIFT / DIVISOR), exact floor for every operand below 2^XW
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);

   logic          step_ff, step_in;   // operand latched, product next
   logic          done_ff, done_in;
   logic [XW-1:0] sum_ff, sum_in;
   logic [SW-1:0] quo_ff, quo_in;
   logic [PW-1:0] prod;

   assign prod = PW'(sum_ff) * PW'(RECIP);

   always_comb begin
      step_in = start;
      done_in = step_ff;
      sum_in  = sum_ff;
      quo_in  = quo_ff;
      if (start) begin
         // adding divisor - 1 turns the floor into a ceiling
         sum_in = XW'(dividend) + XW'(DIVISOR - 1);
      end
      if (step_ff) begin
         quo_in = prod[SHIFT +: SW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      sum_ff <= sum_in;
      quo_ff <= quo_in;
   end

   // never below one sector
   assign status.done       = done_ff;
   assign status.need_count = (quo_ff == '0) ? SW'(1) : quo_ff;

endmodule

@@ rtl/ffsra_status_ram.sv @@
// sector status memory, one write port and one registered read port
// uses ffsra_pkg for the status width
module ffsra_status_ram #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [ADDR_W-1:0]                  wr_addr,
   input  logic [ffsra_pkg::STATUS_W-1:0]     wr_data,
   input  logic [ADDR_W-1:0]                  rd_addr,
   output logic [ffsra_pkg::STATUS_W-1:0]     rd_data
);

   logic [ffsra_pkg::STATUS_W-1:0] mem [DEPTH];
   logic [ffsra_pkg::STATUS_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/first_fit_sector_run_allocator.sv @@
// top level of the first-fit sector run allocator: sequencer, scan, marking
// depends on ffsra_pkg, ffsra_ceil_div and ffsra_status_ram
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  ffsra_pkg::req_type
//  rsp      out        rsp_valid/rsp_stall  ffsra_pkg::rsp_type
//  csr      in         csr_valid/csr_ready  sector count, 13 bits
//
// after reset the status memory is swept to free, sector 0 up to MAX_SECTORS - 1,
// with req stalled; a set item is written as it is taken; an allocate item has
// its size divided, then the scan reads and checks one sector at a time from 0
// toward the limit, then the run found is marked and the result handed off; a
// miss ends the scan at the limit and is handed off unmarked
// req stays stalled while an item is at work; the result sits in an output
// register, so a new item is taken while rsp is stalled
// csr writes are taken in any cycle (csr_ready is always high)
module first_fit_sector_run_allocator #(
   parameter int SECTOR_BYTES = 256,
   parameter int MAX_SECTORS  = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ffsra_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ffsra_pkg::rsp_type                rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ffsra_pkg::COUNT_W-1:0]     csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_SECTORS);
   localparam int CNT_W  = $clog2(MAX_SECTORS + 1);
   localparam int NW     = ffsra_pkg::SIZE_W;
   localparam int IW     = ffsra_pkg::INDEX_W;
   localparam int AW     = ffsra_pkg::ADDRESS_W;
   localparam int CW     = ffsra_pkg::COUNT_W;
   localparam int PROD_W = ADDR_W + $clog2(SECTOR_BYTES + 1);

   ffsra_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;       // shared sweep / scan / mark pointer
   logic [CNT_W-1:0]     run_ff, run_in;       // free sectors in a row
   logic [CNT_W-1:0]     limit_ff, limit_in;   // sectors in use, clipped
   logic [NW-1:0]        need_ff, need_in;
   logic [ADDR_W-1:0]    s_ff, s_in;           // run start
   logic [ADDR_W-1:0]    end_ff, end_in;       // run end
   logic                 found_ff, found_in;
   logic [CW-1:0]        count_ff, count_in;   // sector count register
   logic                 rsp_valid_ff, rsp_valid_in;
   ffsra_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                           slot_free;
   logic                           div_start;
   ffsra_pkg::div_status_type      div_status;
   logic                           ram_we;
   logic [ADDR_W-1:0]              ram_waddr;
   logic [ffsra_pkg::STATUS_W-1:0] ram_wdata;
   logic [ADDR_W-1:0]              ram_raddr;
   logic [ffsra_pkg::STATUS_W-1:0] ram_rdata;
   logic [CNT_W-1:0]               run_inc;
   logic [NW-1:0]                  hit_diff;
   logic [ADDR_W-1:0]              hit_start;
   logic [PROD_W-1:0]              addr_prod;
   logic [NW-1:0]                  taken;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign run_inc   = run_ff + CNT_W'(1);
   // run found ends at idx, so it starts need sectors earlier
   assign hit_diff  = NW'(idx_ff) - need_ff;
   assign hit_start = hit_diff[ADDR_W-1:0];
   assign addr_prod = PROD_W'(s_ff) * PROD_W'(SECTOR_BYTES);
   assign taken     = need_ff + NW'(1);

   ffsra_ceil_div #(
      .DIVISOR (SECTOR_BYTES - 1)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_data.alloc_size),
      .status   (div_status)
   );

   ffsra_status_ram #(
      .DEPTH  (MAX_SECTORS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      run_in       = run_ff;
      limit_in     = limit_ff;
      need_in      = need_ff;
      s_in         = s_ff;
      end_in       = end_ff;
      found_in     = found_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      count_in     = csr_valid ? csr_wdata : count_ff;
      req_stall    = 1'b1;
      div_start    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[ADDR_W-1:0];
      ram_wdata    = ffsra_pkg::STAT_FREE;
      ram_raddr    = idx_ff[ADDR_W-1:0];

      unique case (state_ff)
         // sweep every sector to free after reset
         ffsra_pkg::S_CLEAR: begin
            ram_we = 1'b1;
            if (idx_ff == CNT_W'(MAX_SECTORS - 1)) begin
               idx_in   = '0;
               state_in = ffsra_pkg::S_IDLE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ffsra_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_data.op == ffsra_pkg::OP_SET) begin
                  // a set beyond the store is dropped
                  if (32'(req_data.sector_index) < MAX_SECTORS) begin
                     ram_we    = 1'b1;
                     ram_waddr = ADDR_W'(req_data.sector_index);
                     ram_wdata = req_data.status_code;
                  end
               end else begin
                  div_start = 1'b1;
                  if (32'(count_ff) > MAX_SECTORS) begin
                     limit_in = CNT_W'(MAX_SECTORS);
                  end else begin
                     limit_in = CNT_W'(count_ff);
                  end
                  state_in = ffsra_pkg::S_DIV;
               end
            end
         end
         ffsra_pkg::S_DIV: begin
            if (div_status.done) begin
               need_in  = div_status.need_count;
               idx_in   = '0;
               run_in   = '0;
               state_in = ffsra_pkg::S_SCAN_RD;
            end
         end
         // read address goes out here, status comes back next cycle
         ffsra_pkg::S_SCAN_RD: begin
            if (idx_ff >= limit_ff) begin
               found_in = 1'b0;
               state_in = ffsra_pkg::S_DONE;
            end else begin
               state_in = ffsra_pkg::S_SCAN_CHK;
            end
         end
         ffsra_pkg::S_SCAN_CHK: begin
            if (ram_rdata == ffsra_pkg::STAT_FREE) begin
               if (NW'(run_inc) > need_ff) begin
                  found_in = 1'b1;
                  s_in     = hit_start;
                  end_in   = idx_ff[ADDR_W-1:0];
                  idx_in   = CNT_W'(hit_start);
                  state_in = ffsra_pkg::S_MARK;
               end else begin
                  run_in   = run_inc;
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = ffsra_pkg::S_SCAN_RD;
               end
            end else begin
               // a taken sector breaks the run
               run_in   = '0;
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ffsra_pkg::S_SCAN_RD;
            end
         end
         // write start, used ... used, end, one sector a cycle
         ffsra_pkg::S_MARK: begin
            ram_we = 1'b1;
            if (idx_ff[ADDR_W-1:0] == s_ff) begin
               ram_wdata = ffsra_pkg::STAT_START;
            end else if (idx_ff[ADDR_W-1:0] == end_ff) begin
               ram_wdata = ffsra_pkg::STAT_END;
            end else begin
               ram_wdata = ffsra_pkg::STAT_USED;
            end
            if (idx_ff[ADDR_W-1:0] == end_ff) begin
               state_in = ffsra_pkg::S_DONE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         // hand the item to the output register once it is free
         ffsra_pkg::S_DONE: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_data_in.found = found_ff;
               if (found_ff) begin
                  rsp_data_in.start_sector  = IW'(s_ff);
                  rsp_data_in.start_address = AW'(addr_prod);
                  rsp_data_in.sectors_taken = CW'(taken);
               end else begin
                  rsp_data_in.start_sector  = '0;
                  rsp_data_in.start_address = '0;
                  rsp_data_in.sectors_taken = '0;
               end
               state_in = ffsra_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffsra_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffsra_pkg::S_CLEAR;
         idx_ff       <= '0;
         run_ff       <= '0;
         limit_ff     <= '0;
         found_ff     <= 1'b0;
         count_ff     <= ffsra_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         run_ff       <= run_in;
         limit_ff     <= limit_in;
         found_ff     <= found_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      need_ff     <= need_in;
      s_ff        <= s_in;
      end_ff      <= end_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/ffsra_checker.sv @@
// port-level assertions for the sector run allocator, bound to the top level
// depends on ffsra_pkg and first_fit_sector_run_allocator
module ffsra_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input ffsra_pkg::req_type                req_data,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input ffsra_pkg::rsp_type                rsp_data,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [ffsra_pkg::COUNT_W-1:0]     csr_wdata
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a miss carries nothing but zeros
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.start_sector == '0 && rsp_data.start_address == '0 &&
         rsp_data.sectors_taken == '0)
      else $error("miss result with nonzero fields");

   // a hit covers at least a start and an end sector
   a_hit_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.sectors_taken >= 13'd2)
      else $error("hit result shorter than two sectors");

   // the clearing sweep holds off requests right after reset
   a_clear_stall: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("request taken during clearing sweep");

   // a new result only follows a busy cycle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work");

endmodule

bind first_fit_sector_run_allocator ffsra_checker u_ffsra_checker (.*);
